@@ src/seeded_rgb555_color_variation_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the seeded RGB555 color variation unit
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef SEEDED_RGB555_COLOR_VARIATION_UNIT_MACROS_SVH
`define SEEDED_RGB555_COLOR_VARIATION_UNIT_MACROS_SVH

// Overlapping implication, disabled while reset is asserted.
`define SRCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRCV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define SRCV_ASSERT_NXT_NR(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/srcv_pkg.sv @@
// ---------------------------------------------------------------------------
// srcv_pkg
// Types, constants and helper functions shared by the color variation unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srcv_pkg;

    localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
    localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_STRENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_RANGE = 2'd1;

    localparam logic [3:0] HUE_STRENGTH_RST     = 4'd2;
    localparam logic [4:0] BRIGHTNESS_RANGE_RST = 5'd2;

    // Item class decided by the front end.
    typedef enum logic [1:0] {
        CLS_PASS  = 2'd0,
        CLS_BLACK = 2'd1,
        CLS_VARY  = 2'd2
    } t_cls;

    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] color;
        t_cls        cls;
    } t_item;

    typedef struct packed {
        logic [3:0] hue_strength;
        logic [4:0] brightness_range;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Eight steps of a bit-serial remainder: rem = (2*rem + bit) mod m.
    // The running remainder stays below m, so one compare-subtract per bit.
    function automatic logic [5:0] mod_step8(input logic [5:0] rem,
                                             input logic [7:0] bits,
                                             input logic [5:0] m);
        logic [6:0] t;
        logic [5:0] r;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            r = t[5:0];
        end
        return r;
    endfunction

endpackage

@@ src/srcv_queue.sv @@
// ---------------------------------------------------------------------------
// srcv_queue
// Short FIFO of classified words between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcv_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srcv_pkg::t_item   i_item,
    input  logic              i_pop,
    output srcv_pkg::t_item   o_item,
    output srcv_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srcv_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_do_push;
    logic             w_do_pop;

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == CNT_W'(DEPTH));
        o_item       = r_mem[r_rd_ptr];
        w_do_push    = i_push && !o_stat.full;
        w_do_pop     = i_pop && !o_stat.empty;

        n_wr_ptr = r_wr_ptr;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        n_rd_ptr = r_rd_ptr;
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ src/srcv_front.sv @@
// ---------------------------------------------------------------------------
// srcv_front
// Accepts input words, classifies them and hands them to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_seed,
    input  logic [3:0]        i_entry_index,
    input  logic [15:0]       i_color_in,
    input  srcv_pkg::t_q_stat i_q_stat,
    output logic              o_busy,
    output logic              o_push,
    output srcv_pkg::t_item   o_item
);

    logic            r_vld;
    srcv_pkg::t_item r_item;
    logic            n_vld;
    logic            w_accept;
    srcv_pkg::t_cls  w_cls;

    always_comb begin
        o_push   = r_vld && !i_q_stat.full;
        o_busy   = r_vld && i_q_stat.full;
        o_item   = r_item;
        w_accept = i_start && !o_busy;
        n_vld    = w_accept || (r_vld && !o_push);

        // Transparent entry wins over the black-color shortcut.
        if (i_entry_index == 4'd0) begin
            w_cls = srcv_pkg::CLS_PASS;
        end else if (i_color_in[14:0] == 15'd0) begin
            w_cls = srcv_pkg::CLS_BLACK;
        end else begin
            w_cls = srcv_pkg::CLS_VARY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.seed  <= i_seed;
            r_item.color <= i_color_in;
            r_item.cls   <= w_cls;
        end
    end

endmodule

@@ src/srcv_back.sv @@
// ---------------------------------------------------------------------------
// srcv_back
// Pipelined seed mixer, remainder stages and channel arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  srcv_pkg::t_item i_item,
    input  srcv_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output logic [15:0]     o_color_out
);

    localparam int MOD_STAGES = 4;

    // Mixer stages.
    logic                  r_v1, r_v2, r_v3;
    logic [31:0]           r_p1, r_p2, r_mix;
    logic [15:0]           r_c1, r_c2, r_c3;
    srcv_pkg::t_cls        r_k1, r_k2, r_k3;

    // Remainder stages, eight numerator bits each.
    logic                  r_mv [MOD_STAGES];
    logic [31:0]           r_mx [MOD_STAGES];
    logic [5:0]            r_hr [MOD_STAGES];
    logic [5:0]            r_br [MOD_STAGES];
    logic [15:0]           r_mc [MOD_STAGES];
    srcv_pkg::t_cls        r_mk [MOD_STAGES];

    // Product stage.
    logic                  r_v4;
    logic signed [10:0]    r_prod_r, r_prod_g, r_prod_b;
    logic signed [6:0]     r_bright;
    logic [15:0]           r_c4;
    srcv_pkg::t_cls        r_k4;

    logic [31:0]           w_x0, w_x1, w_p1, w_p2;
    logic [5:0]            w_m_hue, w_m_bri;
    logic [31:0]           w_bri_num;
    logic signed [5:0]     w_hue;
    logic signed [6:0]     w_bright;
    logic [4:0]            w_r, w_g, w_b;
    logic signed [5:0]     w_d_gb, w_d_br, w_d_rg;
    logic signed [10:0]    w_prod_r, w_prod_g, w_prod_b;
    logic [4:0]            w_nr, w_ng, w_nb;
    logic [15:0]           n_color_out;

    function automatic logic [4:0] chan_out(input logic [4:0]         ch,
                                            input logic signed [10:0] prod,
                                            input logic signed [6:0]  bright);
        logic signed [10:0] adj;
        logic signed [10:0] quo;
        logic signed [10:0] sum;
        // Bias negative products so the shift truncates toward zero.
        adj = prod + (prod[10] ? 11'sd15 : 11'sd0);
        quo = adj >>> 4;
        sum = $signed({6'b000000, ch}) + quo + 11'(bright);
        if (sum < 11'sd0) begin
            return 5'd0;
        end else if (sum > 11'sd31) begin
            return 5'd31;
        end
        return sum[4:0];
    endfunction

    always_comb begin
        w_x0 = i_item.seed ^ (i_item.seed >> 16);
        w_p1 = w_x0 * srcv_pkg::MIX_MUL_A;
        w_x1 = r_p1 ^ (r_p1 >> 15);
        w_p2 = w_x1 * srcv_pkg::MIX_MUL_B;

        w_m_hue   = {1'b0, i_cfg.hue_strength, 1'b1};
        w_m_bri   = {i_cfg.brightness_range, 1'b1};
        w_bri_num = {8'd0, r_mix[31:8]};

        w_hue    = $signed({1'b0, r_hr[MOD_STAGES-1][4:0]})
                 - $signed({2'b00, i_cfg.hue_strength});
        w_bright = $signed({1'b0, r_br[MOD_STAGES-1]})
                 - $signed({2'b00, i_cfg.brightness_range});

        w_r = r_mc[MOD_STAGES-1][4:0];
        w_g = r_mc[MOD_STAGES-1][9:5];
        w_b = r_mc[MOD_STAGES-1][14:10];
        w_d_gb = $signed({1'b0, w_g}) - $signed({1'b0, w_b});
        w_d_br = $signed({1'b0, w_b}) - $signed({1'b0, w_r});
        w_d_rg = $signed({1'b0, w_r}) - $signed({1'b0, w_g});
        w_prod_r = w_hue * w_d_gb;
        w_prod_g = w_hue * w_d_br;
        w_prod_b = w_hue * w_d_rg;

        w_nr = chan_out(r_c4[4:0], r_prod_r, r_bright);
        w_ng = chan_out(r_c4[9:5], r_prod_g, r_bright);
        w_nb = chan_out(r_c4[14:10], r_prod_b, r_bright);

        case (r_k4)
            srcv_pkg::CLS_PASS:  n_color_out = r_c4;
            srcv_pkg::CLS_BLACK: n_color_out = 16'd0;
            srcv_pkg::CLS_VARY:  n_color_out = {1'b0, w_nb, w_ng, w_nr};
            default:             n_color_out = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k < MOD_STAGES; k++) begin
                r_mv[k] <= 1'b0;
            end
        end else begin
            r_v1    <= i_vld;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_mv[0] <= r_v3;
            for (int k = 1; k < MOD_STAGES; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            r_v4    <= r_mv[MOD_STAGES-1];
            o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= w_p1;
        r_c1  <= i_item.color;
        r_k1  <= i_item.cls;
        r_p2  <= w_p2;
        r_c2  <= r_c1;
        r_k2  <= r_k1;
        r_mix <= r_p2 ^ (r_p2 >> 16);
        r_c3  <= r_c2;
        r_k3  <= r_k2;

        r_mx[0] <= r_mix;
        r_hr[0] <= srcv_pkg::mod_step8(6'd0, r_mix[31:24], w_m_hue);
        r_br[0] <= srcv_pkg::mod_step8(6'd0, w_bri_num[31:24], w_m_bri);
        r_mc[0] <= r_c3;
        r_mk[0] <= r_k3;
        for (int k = 1; k < MOD_STAGES; k++) begin
            r_mx[k] <= r_mx[k-1];
            r_hr[k] <= srcv_pkg::mod_step8(r_hr[k-1], r_mx[k-1][31-8*k -: 8], w_m_hue);
            r_br[k] <= srcv_pkg::mod_step8(r_br[k-1], r_mx[k-1][31-8*k+8 -: 8], w_m_bri);
            r_mc[k] <= r_mc[k-1];
            r_mk[k] <= r_mk[k-1];
        end

        r_prod_r <= w_prod_r;
        r_prod_g <= w_prod_g;
        r_prod_b <= w_prod_b;
        r_bright <= w_bright;
        r_c4     <= r_mc[MOD_STAGES-1];
        r_k4     <= r_mk[MOD_STAGES-1];

        o_color_out <= n_color_out;
    end

endmodule

@@ src/seeded_rgb555_color_variation_unit.sv @@
// ---------------------------------------------------------------------------
// seeded_rgb555_color_variation_unit
// Seeded hue and brightness variation of RGB555 palette colors.
//
//   Channel  | Handshake                  | Words
//   ---------+----------------------------+---------------------------------
//   input    | i_start / o_busy           | i_seed, i_entry_index, i_color_in
//   result   | o_valid strobe, no stall   | o_color_out
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while o_busy is low; o_valid is a strobe,
// one cycle wide, that marks o_color_out.
// The latency is set by the front register, the queue, the two mixer
// multiplies and final xor, four remainder stages of eight bits each, the
// channel product stage and the output register.
// Reset is synchronous, active low, and clears all valid flags and pointers.
// The back end never stalls, so o_busy stays low in normal operation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module seeded_rgb555_color_variation_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [31:0]                     i_seed,
    input  logic [3:0]                      i_entry_index,
    input  logic [15:0]                     i_color_in,
    output logic                            o_valid,
    output logic [15:0]                     o_color_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srcv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srcv_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    srcv_pkg::t_cfg    r_cfg;
    srcv_pkg::t_cfg    n_cfg;
    srcv_pkg::t_q_stat w_q_stat;
    srcv_pkg::t_item   w_front_item;
    srcv_pkg::t_item   w_head_item;
    logic              w_push;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                srcv_pkg::REG_HUE_STRENGTH:     n_cfg.hue_strength = i_cfg_data[3:0];
                srcv_pkg::REG_BRIGHTNESS_RANGE: n_cfg.brightness_range = i_cfg_data[4:0];
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_strength     <= srcv_pkg::HUE_STRENGTH_RST;
            r_cfg.brightness_range <= srcv_pkg::BRIGHTNESS_RANGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    srcv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_seed        (i_seed),
        .i_entry_index (i_entry_index),
        .i_color_in    (i_color_in),
        .i_q_stat      (w_q_stat),
        .o_busy        (o_busy),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    srcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (!w_q_stat.empty),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    // The back end takes the queue head every cycle it is present.
    srcv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (!w_q_stat.empty),
        .i_item      (w_head_item),
        .i_cfg       (r_cfg),
        .o_valid     (o_valid),
        .o_color_out (o_color_out)
    );

endmodule

@@ src/srcv_checker.sv @@
// ---------------------------------------------------------------------------
// srcv_checker
// Port-level checks of the color variation unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "seeded_rgb555_color_variation_unit_macros.svh"

module srcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        i_busy,
    input logic [3:0]  i_entry_index,
    input logic [15:0] i_color_in,
    input logic        i_valid,
    input logic [15:0] i_color_out
);

    localparam int LAT = 11;

    logic w_accept;

    assign w_accept = i_start && !i_busy;

    // Reset empties the pipeline: no strobe in the cycle after it.
    `SRCV_ASSERT_NXT_NR(a_reset_quiet, i_clk, !i_rst_n, !i_valid, "strobe right after reset")

    // Every accepted word yields a result after the fixed latency.
    `SRCV_ASSERT_IMP(a_result_follows, i_clk, i_rst_n, w_accept, ##LAT i_valid, "result missing")

    // A transparent entry comes back unchanged, bit 15 included.
    `SRCV_ASSERT_IMP(a_pass_through, i_clk, i_rst_n, w_accept && i_entry_index == 4'd0, ##LAT (i_valid && i_color_out == $past(i_color_in, LAT)), "transparent entry altered")

    // A black color on a visible entry comes back as zero.
    `SRCV_ASSERT_IMP(a_black_zero, i_clk, i_rst_n, w_accept && i_entry_index != 4'd0 && i_color_in[14:0] == 15'd0, ##LAT (i_valid && i_color_out == 16'd0), "black color not zero")

endmodule

bind seeded_rgb555_color_variation_unit srcv_checker u_srcv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_busy        (o_busy),
    .i_entry_index (i_entry_index),
    .i_color_in    (i_color_in),
    .i_valid       (o_valid),
    .i_color_out   (o_color_out)
);
